### rtl/core/grqs_pkg.sv
// Shared types, codes and the goodness function of the ready queue scheduler.
package grqs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int SCORE_W = 18;

   typedef logic signed [SCORE_W-1:0] score_type;

   localparam score_type RT_BASE = 18'sd1000;
   localparam score_type NICE_BASE = 18'sd20;
   localparam score_type NO_SCORE = -18'sd2000;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_GRANTED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0]       task_id;
      logic              is_realtime;
      logic [6:0]        rt_prio;
      logic signed [5:0] nice_value;
      logic [2:0]        affinity_cpu;
      logic [15:0]       burst_left;
   } entry_type;

   typedef struct packed {
      logic        valid;
      score_type   best;
      logic [15:0] id;
   } token_type;

   typedef struct packed {
      logic       write;
      logic       shift;
      logic [2:0] cpu;
   } cell_ctrl_type;

   function automatic score_type score_of(input entry_type e, input logic [2:0] cpu);
      score_type s;
      if (e.is_realtime) begin
         s = RT_BASE + $signed({11'b0, e.rt_prio});
      end else begin
         s = $signed({2'b0, e.burst_left})
             + $signed({17'b0, (e.affinity_cpu == cpu)})
             + NICE_BASE - score_type'(e.nice_value);
      end
      return s;
   endfunction

endpackage

### rtl/core/grqs_req_if.sv
// Request channel carrying enqueue and grant commands.
interface grqs_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic [2:0]        requesting_cpu;
   logic [15:0]       task_id;
   logic              is_realtime;
   logic [6:0]        rt_prio;
   logic signed [5:0] nice_value;
   logic [2:0]        affinity_cpu;
   logic [15:0]       burst_left;

   modport source (
      output valid, command, requesting_cpu, task_id, is_realtime, rt_prio,
             nice_value, affinity_cpu, burst_left,
      input  ready
   );
   modport sink (
      input  valid, command, requesting_cpu, task_id, is_realtime, rt_prio,
             nice_value, affinity_cpu, burst_left,
      output ready
   );
endinterface

### rtl/core/grqs_rsp_if.sv
// Response channel carrying the status and grant of each command.
interface grqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] granted_task_id;
   logic [16:0] granted_score;
   logic [4:0]  queue_count;

   modport source (
      output valid, status, granted_task_id, granted_score, queue_count,
      input  ready
   );
   modport sink (
      input  valid, status, granted_task_id, granted_score, queue_count,
      output ready
   );
endinterface

### rtl/core/grqs_cell.sv
// One queue slot: holds a task, scores it and passes the running best along the row.
module grqs_cell #(
   parameter int QUEUE_DEPTH = grqs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  grqs_pkg::cell_ctrl_type            ctrl,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     pick,
   input  grqs_pkg::entry_type                new_entry,
   input  grqs_pkg::entry_type                next_entry,
   output grqs_pkg::entry_type                entry_out,
   input  grqs_pkg::token_type                tok_prev,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     idx_prev,
   output grqs_pkg::token_type                tok_out,
   output logic [$clog2(QUEUE_DEPTH)-1:0]     idx_out
);
   import grqs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

   entry_type        entry_ff;
   entry_type        entry_in;
   token_type        tok_ff;
   token_type        tok_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   score_type        own_score;
   logic             occupied;
   logic             take;

   assign own_score = score_of(entry_ff, ctrl.cpu);
   assign occupied  = MY_CNT < count;
   assign take      = tok_prev.valid && occupied && (own_score > tok_prev.best);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write && (count == MY_CNT)) begin
         entry_in = new_entry;
      end else if (ctrl.shift && (MY_IDX >= pick)) begin
         entry_in = next_entry;
      end
      tok_in.valid = tok_prev.valid;
      tok_in.best  = take ? own_score : tok_prev.best;
      tok_in.id    = take ? entry_ff.task_id : tok_prev.id;
      idx_in       = take ? MY_IDX : idx_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.best <= tok_in.best;
      tok_ff.id   <= tok_in.id;
      idx_ff      <= idx_in;
      entry_ff    <= entry_in;
   end

   assign entry_out = entry_ff;
   assign tok_out   = tok_ff;
   assign idx_out   = idx_ff;

endmodule

### rtl/core/goodness_ready_queue_scheduler_top.sv
// Goodness-scored ready queue built as a row of task cells with a command sequencer.
//
// The req_bus channel takes one command per transfer. An enqueue stores the task at
// the tail of the queue or answers full status; a request answers empty status on an
// empty queue, else it scores every queued task for the asking CPU and grants the
// best one, the oldest on a tie, then closes the gap. Every command yields exactly
// one transfer on rsp_bus with status, granted id and score (zero unless granted)
// and the queue count after the command. Commands are handled one at a time. An
// enqueue or an empty request goes to the done state, which loads its result into
// the output register. A grant first sends a scan token along the row of cells one
// cell per cycle, collecting the running best score; the sequencer then captures
// the winner, shifts the cells behind it forward and loads the output register.
// The next command is taken once the sequencer is back in idle.
// The result sits in an output register, so a new command is taken while the
// previous result still waits; a command that completes while the receiver stalls
// is held until the output register frees up.
// Reset empties the queue at once; the cells' task storage is not cleared and no
// clearing pass is needed.
module goodness_ready_queue_scheduler_top #(
   parameter int QUEUE_DEPTH = grqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   grqs_req_if.sink   req_bus,
   grqs_rsp_if.source rsp_bus
);
   import grqs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             start_ff, start_in;
   logic [2:0]       cpu_ff, cpu_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   status_type       pend_status_ff, pend_status_in;
   logic [15:0]      pend_id_ff, pend_id_in;
   logic [16:0]      pend_score_ff, pend_score_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [15:0]      rsp_id_ff, rsp_id_in;
   logic [16:0]      rsp_score_ff, rsp_score_in;
   logic [4:0]       rsp_count_ff, rsp_count_in;

   entry_type        new_entry;
   entry_type        entries [QUEUE_DEPTH];
   token_type        toks [QUEUE_DEPTH+1];
   logic [IDX_W-1:0] idxs [QUEUE_DEPTH+1];
   cell_ctrl_type    ctrl;
   logic             req_fire;
   logic             full;
   logic             scan_done;
   token_type        tok_last;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign full          = (count_ff == CNT_W'(QUEUE_DEPTH));

   assign new_entry.task_id      = req_bus.task_id;
   assign new_entry.is_realtime  = req_bus.is_realtime;
   assign new_entry.rt_prio      = req_bus.rt_prio;
   assign new_entry.nice_value   = req_bus.nice_value;
   assign new_entry.affinity_cpu = req_bus.affinity_cpu;
   assign new_entry.burst_left   = req_bus.burst_left;

   assign ctrl.write = req_fire && (req_bus.command == CMD_ENQUEUE) && !full;
   assign ctrl.shift = (state_ff == ST_SHIFT);
   assign ctrl.cpu   = cpu_ff;

   assign toks[0].valid = start_ff;
   assign toks[0].best  = NO_SCORE;
   assign toks[0].id    = '0;
   assign idxs[0]       = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      grqs_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .pick       (pick_ff),
         .new_entry  (new_entry),
         .next_entry (entries[(i + 1 < QUEUE_DEPTH) ? i + 1 : i]),
         .entry_out  (entries[i]),
         .tok_prev   (toks[i]),
         .idx_prev   (idxs[i]),
         .tok_out    (toks[i+1]),
         .idx_out    (idxs[i+1])
      );
   end

   assign tok_last  = toks[QUEUE_DEPTH];
   assign scan_done = tok_last.valid;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      start_in       = 1'b0;
      cpu_in         = cpu_ff;
      pick_in        = pick_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      pend_score_in  = pend_score_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_score_in   = rsp_score_ff;
      rsp_count_in   = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pend_id_in    = '0;
               pend_score_in = '0;
               if (req_bus.command == CMD_ENQUEUE) begin
                  state_in = ST_DONE;
                  if (full) begin
                     pend_status_in = STATUS_FULL;
                  end else begin
                     pend_status_in = STATUS_ENQUEUED;
                     count_in       = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  state_in       = ST_DONE;
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  state_in = ST_SCAN;
                  start_in = 1'b1;
                  cpu_in   = req_bus.requesting_cpu;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in       = ST_SHIFT;
               pick_in        = idxs[QUEUE_DEPTH];
               pend_status_in = STATUS_GRANTED;
               pend_id_in     = tok_last.id;
               pend_score_in  = tok_last.best[SCORE_W-1] ? '0 : tok_last.best[16:0];
            end
         end
         ST_SHIFT: begin
            state_in = ST_DONE;
            count_in = count_ff - CNT_W'(1);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_id_in     = pend_id_ff;
               rsp_score_in  = pend_score_ff;
               rsp_count_in  = 5'(count_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cpu_ff         <= cpu_in;
      pick_ff        <= pick_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      pend_score_ff  <= pend_score_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_score_ff   <= rsp_score_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.granted_task_id = rsp_id_ff;
   assign rsp_bus.granted_score   = rsp_score_ff;
   assign rsp_bus.queue_count     = rsp_count_ff;

   // The scan token only reaches the end of the row while a grant is in progress.
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (state_ff == ST_SCAN))
      else $error("scan token arrived outside of a grant");

   // A stored task raises the queue count by exactly one.
   a_enqueue_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.write |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow an enqueue");

   // Closing the gap after a grant lowers the queue count by exactly one.
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue count did not follow a grant");

   // The queue never holds more tasks than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (count_ff <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue count exceeds the queue depth");

endmodule

### dv/testbench.sv
// Self-checking testbench for the goodness-scored ready queue scheduler.
`timescale 1ns / 1ps

module testbench;
   import grqs_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1720;
   localparam int GOODNESS_RT_BASE = 1000;
   localparam int GOODNESS_NICE_BASE = 20;
   localparam int GOODNESS_FLOOR = -2000;

   typedef struct {
      logic      command;
      logic [2:0] cpu;
      entry_type body;
   } cmd_item_type;

   typedef struct {
      status_type  status;
      logic [15:0] task_id;
      logic [16:0] score;
      logic [4:0]  count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   grqs_req_if req_bus();
   grqs_rsp_if rsp_bus();

   goodness_ready_queue_scheduler_top #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   entry_type   model_tasks[$];
   outcome_type awaited_outcomes[$];
   int          errors = 0;
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int goodness_of(input entry_type e, input logic [2:0] cpu);
      if (e.is_realtime) begin
         return GOODNESS_RT_BASE + int'(e.rt_prio);
      end
      return int'(e.burst_left) + ((e.affinity_cpu == cpu) ? 1 : 0)
             + GOODNESS_NICE_BASE - int'($signed(e.nice_value));
   endfunction

   function automatic outcome_type predict_outcome(input cmd_item_type it);
      outcome_type o;
      int best;
      int pick;
      int v;
      o.status = STATUS_ENQUEUED;
      o.task_id = '0;
      o.score = '0;
      if (it.command == CMD_ENQUEUE) begin
         if (model_tasks.size() >= DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            model_tasks = {model_tasks, it.body};
         end
      end else if (model_tasks.size() == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         best = GOODNESS_FLOOR;
         pick = 0;
         foreach (model_tasks[i]) begin
            v = goodness_of(model_tasks[i], it.cpu);
            if (v > best) begin
               best = v;
               pick = i;
            end
         end
         o.status = STATUS_GRANTED;
         o.task_id = model_tasks[pick].task_id;
         o.score = (best < 0) ? 17'd0 : 17'(best);
         model_tasks.delete(pick);
      end
      o.count = 5'(model_tasks.size());
      return o;
   endfunction

   function automatic cmd_item_type make_enqueue(input logic [15:0] id, input logic rt,
                                                 input logic [6:0] prio,
                                                 input logic signed [5:0] nice,
                                                 input logic [2:0] cpu,
                                                 input logic [15:0] rem);
      cmd_item_type it;
      it.command = CMD_ENQUEUE;
      it.cpu = 3'($urandom);
      it.body.task_id = id;
      it.body.is_realtime = rt;
      it.body.rt_prio = prio;
      it.body.nice_value = nice;
      it.body.affinity_cpu = cpu;
      it.body.burst_left = rem;
      return it;
   endfunction

   function automatic cmd_item_type make_request(input logic [2:0] cpu);
      cmd_item_type it;
      it.command = CMD_REQUEST;
      it.cpu = cpu;
      it.body = '0;
      return it;
   endfunction

   function automatic cmd_item_type random_item(input int enq_weight);
      cmd_item_type it;
      it.command = ($urandom_range(0, 99) < enq_weight) ? CMD_ENQUEUE : CMD_REQUEST;
      it.cpu = 3'($urandom);
      it.body.task_id = 16'($urandom);
      it.body.is_realtime = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
         0: it.body.rt_prio = 7'($urandom);
         1: it.body.rt_prio = 7'($urandom_range(0, 3));
         default: it.body.rt_prio = 7'($urandom_range(0, 99));
      endcase
      if ($urandom_range(0, 9) == 0) begin
         it.body.nice_value = 6'($urandom);
      end else begin
         it.body.nice_value = 6'(int'($urandom_range(0, 39)) - 20);
      end
      it.body.affinity_cpu = 3'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         it.body.burst_left = 16'($urandom_range(0, 40));
      end else begin
         it.body.burst_left = 16'($urandom);
      end
      return it;
   endfunction

   task automatic send_item(input cmd_item_type it);
      int gap;
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= it.command;
      req_bus.requesting_cpu <= it.cpu;
      req_bus.task_id <= it.body.task_id;
      req_bus.is_realtime <= it.body.is_realtime;
      req_bus.rt_prio <= it.body.rt_prio;
      req_bus.nice_value <= it.body.nice_value;
      req_bus.affinity_cpu <= it.body.affinity_cpu;
      req_bus.burst_left <= it.body.burst_left;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      awaited_outcomes = {awaited_outcomes, predict_outcome(it)};
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_queue();
      cmd_item_type it;
      send_item(make_request(3'd0));
      it = make_request(3'd7);
      it.body = '1;
      send_item(it);
      wait_for_results();
   endtask

   task automatic test_affinity_and_ties();
      send_item(make_enqueue(16'hA001, 1'b0, 7'd0, 6'sd0, 3'd7, 16'd100));
      send_item(make_enqueue(16'hB002, 1'b0, 7'd0, 6'sd0, 3'd0, 16'd100));
      send_item(make_enqueue(16'hC003, 1'b0, 7'd0, 6'sd0, 3'd0, 16'd100));
      send_item(make_request(3'd0));
      send_item(make_request(3'd7));
      send_item(make_request(3'd0));
      wait_for_results();
   endtask

   task automatic test_negative_scores();
      send_item(make_enqueue(16'h0E01, 1'b0, 7'd0, 6'sd31, 3'd5, 16'd0));
      send_item(make_enqueue(16'h0E02, 1'b0, 7'd0, 6'sd21, 3'd5, 16'd0));
      send_item(make_request(3'd1));
      send_item(make_request(3'd1));
      wait_for_results();
   endtask

   task automatic test_fill_and_overflow();
      send_item(make_enqueue(16'h0000, 1'b0, 7'd0, -6'sd32, 3'd0, 16'h0000));
      send_item(make_enqueue(16'hFFFF, 1'b1, 7'd127, 6'sd31, 3'd7, 16'hFFFF));
      send_item(make_enqueue(16'h0001, 1'b1, 7'd0, -6'sd20, 3'd3, 16'd5));
      send_item(make_enqueue(16'h0002, 1'b1, 7'd99, 6'sd19, 3'd4, 16'd9));
      send_item(make_enqueue(16'h0003, 1'b0, 7'd127, -6'sd20, 3'd7, 16'hFFFF));
      send_item(make_enqueue(16'h0004, 1'b0, 7'd99, 6'sd19, 3'd0, 16'h0000));
      for (int k = 6; k < DEPTH; k++) begin
         send_item(make_enqueue(16'(16'h1000 + k), 1'(k), 7'(k * 9), 6'(k * 5 - 32),
                                3'(k), 16'(k * 4099)));
      end
      send_item(make_enqueue(16'h5A5A, 1'b1, 7'd50, 6'sd0, 3'd2, 16'd1));
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int sent;
      int chunk;
      int enq_weight;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         chunk = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enq_weight = 80;
            1: enq_weight = 50;
            default: enq_weight = 25;
         endcase
         sender_idles = 1'($urandom_range(0, 1));
         receiver_idles = 1'($urandom_range(0, 1));
         repeat (chunk) begin
            send_item(random_item(enq_weight));
            sent++;
         end
         if ($urandom_range(0, 7) == 0) begin
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = receiver_idles ? $urandom_range(0, 8) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result transfer, status %0d id %0d", $time,
                     rsp_bus.status, rsp_bus.granted_task_id);
            errors++;
         end else begin
            want = awaited_outcomes[0];
            awaited_outcomes.delete(0);
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               errors++;
            end
            if (rsp_bus.granted_task_id !== want.task_id) begin
               $display("%0t: granted_task_id expected %0d actual %0d", $time,
                        want.task_id, rsp_bus.granted_task_id);
               errors++;
            end
            if (rsp_bus.granted_score !== want.score) begin
               $display("%0t: granted_score expected %0d actual %0d", $time, want.score,
                        rsp_bus.granted_score);
               errors++;
            end
            if (rsp_bus.queue_count !== want.count) begin
               $display("%0t: queue_count expected %0d actual %0d", $time, want.count,
                        rsp_bus.queue_count);
               errors++;
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_ENQUEUE;
      req_bus.requesting_cpu = '0;
      req_bus.task_id = '0;
      req_bus.is_realtime = 1'b0;
      req_bus.rt_prio = '0;
      req_bus.nice_value = '0;
      req_bus.affinity_cpu = '0;
      req_bus.burst_left = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_affinity_and_ties();
      test_negative_scores();
      test_fill_and_overflow();
      test_random_traffic();
      repeat (DEPTH + 8) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/grqs_pkg.sv
rtl/core/grqs_req_if.sv
rtl/core/grqs_rsp_if.sv
rtl/core/grqs_cell.sv
rtl/core/goodness_ready_queue_scheduler_top.sv
dv/testbench.sv
